### src/rtfp_pkg.sv
// shared types and constants for the radix text to fixed-point parser
`default_nettype none

package rtfp_pkg;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_BAD_LEN  = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2,
    RADIX_ALT = 2'd3
  } radix_t;

  localparam logic [7:0] CHAR_POINT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;

  localparam logic [5:0] COUNT_MAX = 6'd63;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] fixed_value;
    logic [1:0]  status_code;
  } out_beat_t;

endpackage

`default_nettype wire

### src/radix_text_to_fixed_point.sv
// top level: ascii base 2/8/16 number text to unsigned fixed-point value
`default_nettype none

// Takes one character per beat and can accept a new character in every cycle.
// Each character updates the parse state (integer and fraction accumulators,
// point, counts and error flags) in one pass of shift-and-or logic. The beat
// flagged last_char also loads the result register at its accepting edge,
// with fixed_value = {integer, fraction} and status_code, and out_valid
// rises in the cycle after. Only a last character waits for the result
// register to drain; other characters keep flowing while a result still
// waits on out_ready. radix_r is written through cfg_wr_en / cfg_wr_data;
// the user must write it only while no string is in flight, which the block
// does not enforce; code 3 acts as hexadecimal. Integer overflow saturates
// the value to all ones; a bad length or bad character gives a value of zero.
module radix_text_to_fixed_point import rtfp_pkg::*; #(
  parameter int INT_BITS  = 48,
  parameter int FRAC_BITS = 16,
  parameter int MAX_CHARS = 49
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_wr_en,
  input  wire logic [1:0] cfg_wr_data,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);

  localparam int FW = (FRAC_BITS > 0) ? FRAC_BITS : 1;
  localparam int EW = FW + 4;
  localparam int VW = INT_BITS + FW;
  localparam logic [7:0] SHIFT_LIM = 8'(FRAC_BITS + 4);
  localparam logic [5:0] LEN_LIMIT = 6'(MAX_CHARS);

  radix_t                radix_r;
  logic [INT_BITS-1:0]   int_r, int_nxt;
  logic [FW-1:0]         frac_r, frac_nxt;
  logic                  point_r, point_nxt;
  logic [5:0]            fdc_r, fdc_nxt;
  logic [5:0]            cc_r, cc_nxt;
  logic                  len_r, len_nxt;
  logic                  bad_r, bad_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  out_valid_r;
  out_beat_t             out_r, out_nxt;

  logic                  accept;
  logic [2:0]            bps;
  logic                  is_digit;
  logic [3:0]            dval;
  logic                  in_range;
  logic                  top_busy;
  logic [7:0]            prod;
  logic [EW-1:0]         ext;
  logic [VW-1:0]         val_wide;
  logic [VW-1:0]         sat_wide;

  // only the last character needs room in the result register
  assign in_ready = !out_valid_r || out_ready || !in_data.last_char;
  assign accept   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    unique case (radix_r)
      RADIX_BIN: bps = 3'd1;
      RADIX_OCT: bps = 3'd3;
      default:   bps = 3'd4;
    endcase
  end

  // digit decode, upper-case hex only
  always_comb begin
    is_digit = 1'b0;
    dval     = 4'd0;
    if (in_data.char_code >= CHAR_ZERO && in_data.char_code <= CHAR_NINE) begin
      is_digit = 1'b1;
      dval     = in_data.char_code[3:0];
    end else if (in_data.char_code >= CHAR_UPPER_A &&
                 in_data.char_code <= CHAR_UPPER_F) begin
      is_digit = 1'b1;
      dval     = 4'(in_data.char_code[3:0] + 4'd9);
    end
    unique case (radix_r)
      RADIX_BIN: in_range = is_digit && (dval[3:1] == 3'd0);
      RADIX_OCT: in_range = is_digit && !dval[3];
      default:   in_range = is_digit;
    endcase
    unique case (radix_r)
      RADIX_BIN: top_busy = int_r[INT_BITS-1];
      RADIX_OCT: top_busy = |int_r[INT_BITS-1 -: 3];
      default:   top_busy = |int_r[INT_BITS-1 -: 4];
    endcase
  end

  always_comb begin
    int_nxt   = int_r;
    frac_nxt  = frac_r;
    point_nxt = point_r;
    fdc_nxt   = fdc_r;
    cc_nxt    = cc_r;
    len_nxt   = len_r;
    bad_nxt   = bad_r;
    ovf_nxt   = ovf_r;
    prod      = 8'd0;
    ext       = '0;

    if (cc_r >= LEN_LIMIT) len_nxt = 1'b1;
    if (cc_r != COUNT_MAX) cc_nxt = 6'(cc_r + 6'd1);

    if (in_data.char_code == CHAR_POINT) begin
      if (point_r) bad_nxt = 1'b1;
      else point_nxt = 1'b1;
    end else if (!in_range) begin
      bad_nxt = 1'b1;
    end else if (!point_r) begin
      if (top_busy) ovf_nxt = 1'b1;
      int_nxt = (int_r << bps) | INT_BITS'(dval);
    end else begin
      if (fdc_r != COUNT_MAX) fdc_nxt = 6'(fdc_r + 6'd1);
      prod = 8'(bps) * 8'(fdc_nxt);
      // digit lands 4 bits up in ext so partial bits below the format survive
      if (prod <= SHIFT_LIM) ext = EW'(dval) << (SHIFT_LIM - prod);
      if (FRAC_BITS > 0) frac_nxt = frac_r | ext[EW-1:4];
    end
  end

  always_comb begin
    val_wide = {int_nxt, frac_nxt} >> (FW - FRAC_BITS);
    sat_wide = {VW{1'b1}} >> (FW - FRAC_BITS);
    out_nxt.fixed_value = 64'(val_wide);
    out_nxt.status_code = STATUS_OK;
    if (len_nxt) begin
      out_nxt.fixed_value = '0;
      out_nxt.status_code = STATUS_BAD_LEN;
    end else if (bad_nxt) begin
      out_nxt.fixed_value = '0;
      out_nxt.status_code = STATUS_BAD_CHAR;
    end else if (ovf_nxt) begin
      out_nxt.fixed_value = 64'(sat_wide);
      out_nxt.status_code = STATUS_OVERFLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= RADIX_BIN;
      int_r       <= '0;
      frac_r      <= '0;
      point_r     <= 1'b0;
      fdc_r       <= '0;
      cc_r        <= '0;
      len_r       <= 1'b0;
      bad_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) radix_r <= radix_t'(cfg_wr_data);
      if (accept && in_data.last_char) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (accept) begin
        if (in_data.last_char) begin
          // string done, start the next one clean
          int_r       <= '0;
          frac_r      <= '0;
          point_r     <= 1'b0;
          fdc_r       <= '0;
          cc_r        <= '0;
          len_r       <= 1'b0;
          bad_r       <= 1'b0;
          ovf_r       <= 1'b0;
        end else begin
          int_r   <= int_nxt;
          frac_r  <= frac_nxt;
          point_r <= point_nxt;
          fdc_r   <= fdc_nxt;
          cc_r    <= cc_nxt;
          len_r   <= len_nxt;
          bad_r   <= bad_nxt;
          ovf_r   <= ovf_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_char) out_r <= out_nxt;
  end

endmodule

`default_nettype wire
